// File: rtl/core/multicast_route_table_defines.svh
// ----------------------------------------------------------------------------
// multicast_route_table_defines: assertion macros
// Shared concurrent assertion forms for the route table checks.
// ----------------------------------------------------------------------------
`ifndef MULTICAST_ROUTE_TABLE_DEFINES_SVH
`define MULTICAST_ROUTE_TABLE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MRT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("multicast_route_table: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define MRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("multicast_route_table: next-cycle check failed");

`endif

// File: rtl/core/mrt_pkg.sv
// ----------------------------------------------------------------------------
// mrt_pkg: multicast route table shared definitions
// Table depth, command and status codes, and the request and chain types.
// ----------------------------------------------------------------------------
package mrt_pkg;

  // number of route slots, one cell each
  localparam int unsigned TableEntries = 16;

  // command codes
  localparam logic [1:0] CmdUpsert  = 2'd0;
  localparam logic [1:0] CmdSetPrev = 2'd1;
  localparam logic [1:0] CmdRemove  = 2'd2;
  localparam logic [1:0] CmdLookup  = 2'd3;

  // status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNotFound = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;

  // request broadcast to every cell
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] prev_hop;
    logic [7:0]  hops;
  } req_t;

  // flags and hit data passed from cell to cell along the row
  typedef struct packed {
    logic        hit;
    logic        free_seen;
    logic [7:0]  hops;
    logic [31:0] prev_hop;
  } chain_t;

endpackage

// File: rtl/core/mrt_cell.sv
// ----------------------------------------------------------------------------
// mrt_cell: one route slot of the table row
// Holds one entry, compares it with the request, extends the hit and
// free-slot chain, and applies the command when the execute strobe fires.
// ----------------------------------------------------------------------------
module mrt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            exec_i,
  input  mrt_pkg::req_t   req_i,
  input  logic            any_hit_i,
  input  mrt_pkg::chain_t chain_i,
  output mrt_pkg::chain_t chain_o
);

  logic        valid_q, valid_d;
  logic [31:0] key_q, key_d;
  logic [31:0] prev_q, prev_d;
  logic [7:0]  hops_q, hops_d;
  logic        match;
  logic        first_free;

  // key compare and chain extension
  assign match      = valid_q && (key_q == req_i.key);
  assign first_free = !valid_q && !chain_i.free_seen;

  always_comb begin
    chain_o.hit       = chain_i.hit | match;
    chain_o.free_seen = chain_i.free_seen | !valid_q;
    chain_o.hops      = chain_i.hops | (match ? hops_q : 8'd0);
    chain_o.prev_hop  = chain_i.prev_hop | (match ? prev_q : 32'd0);
  end

  // command update of this slot
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    prev_d  = prev_q;
    hops_d  = hops_q;
    if (exec_i) begin
      case (req_i.cmd)
        mrt_pkg::CmdUpsert: begin
          if (match) begin
            prev_d = req_i.prev_hop;
            hops_d = req_i.hops;
          end else if (!any_hit_i && first_free) begin
            valid_d = 1'b1;
            key_d   = req_i.key;
            prev_d  = req_i.prev_hop;
            hops_d  = req_i.hops;
          end
        end
        mrt_pkg::CmdSetPrev: begin
          if (match) begin
            prev_d = req_i.prev_hop;
          end
        end
        mrt_pkg::CmdRemove: begin
          if (match) begin
            valid_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // valid bit, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    prev_q <= prev_d;
    hops_q <= hops_d;
  end

endmodule

// File: rtl/core/multicast_route_table.sv
// Timing: a command transferred at one edge is held in the request register and
// executed once the result register is free; the result is then registered.
// Flow: one command in flight; no new command is taken until the compare-then-write
// pass through the row of route cells is done while the request register is held.
// Reset: rst_ni clears all slot valid bits and the handshake state; the table
// is empty and ready for a command in the first cycle after reset.
// ----------------------------------------------------------------------------
// multicast_route_table: associative multicast route table
// Upsert, set previous hop, remove and lookup over a row of route cells.
// ----------------------------------------------------------------------------
module multicast_route_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] group_address_i,
  input  logic [31:0] prev_hop_in_i,
  input  logic [7:0]  hop_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  hop_out_o,
  output logic [31:0] prev_hop_out_o
);

  logic            busy_q, busy_d;
  logic            out_valid_q, out_valid_d;
  mrt_pkg::req_t   req_q;
  logic [1:0]      status_q, status_d;
  logic [7:0]      hop_q, hop_d;
  logic [31:0]     prev_q, prev_d;
  logic            in_fire;
  logic            exec;
  mrt_pkg::chain_t chain [mrt_pkg::TableEntries+1];
  mrt_pkg::chain_t chain_end;

  // handshake
  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && !busy_q;
  assign exec       = busy_q && (!out_valid_q || out_ready_i);

  // row of route cells
  assign chain[0] = '0;

  for (genvar g = 0; g < mrt_pkg::TableEntries; g++) begin : g_cell
    mrt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .exec_i    (exec),
      .req_i     (req_q),
      .any_hit_i (chain_end.hit),
      .chain_i   (chain[g]),
      .chain_o   (chain[g+1])
    );
  end

  assign chain_end = chain[mrt_pkg::TableEntries];

  // result of the command
  always_comb begin
    status_d = mrt_pkg::StatusOk;
    hop_d    = 8'd0;
    prev_d   = 32'd0;
    case (req_q.cmd)
      mrt_pkg::CmdUpsert: begin
        if (!chain_end.hit && !chain_end.free_seen) begin
          status_d = mrt_pkg::StatusFull;
        end
      end
      mrt_pkg::CmdLookup: begin
        if (chain_end.hit) begin
          hop_d  = chain_end.hops;
          prev_d = chain_end.prev_hop;
        end else begin
          status_d = mrt_pkg::StatusNotFound;
        end
      end
      default: begin
        if (!chain_end.hit) begin
          status_d = mrt_pkg::StatusNotFound;
        end
      end
    endcase
  end

  // control next state
  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (exec) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
    end
    if (in_fire) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request capture on input transfer
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q.cmd      <= command_i;
      req_q.key      <= group_address_i;
      req_q.prev_hop <= prev_hop_in_i;
      req_q.hops     <= hop_in_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (exec) begin
      status_q <= status_d;
      hop_q    <= hop_d;
      prev_q   <= prev_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign hop_out_o      = hop_q;
  assign prev_hop_out_o = prev_q;

endmodule

// File: rtl/core/mrt_checker.sv
// ----------------------------------------------------------------------------
// mrt_checker: port-level checks for the multicast route table
// Watches the top-level handshakes and result fields over time.
// ----------------------------------------------------------------------------
`include "multicast_route_table_defines.svh"

module mrt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [7:0]  hop_out_o,
  input logic [31:0] prev_hop_out_o
);

  // a stalled result holds
  `MRT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(hop_out_o) && $stable(prev_hop_out_o))

  // failed commands return zero data
  `MRT_ASSERT_IMPLY(a_fail_zero, clk_i, rst_ni, out_valid_o && (status_o != mrt_pkg::StatusOk), (hop_out_o == 8'd0) && (prev_hop_out_o == 32'd0))

  // one command in flight: no transfer in the cycle after one
  `MRT_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // a new result only follows a command being worked on
  `MRT_ASSERT_IMPLY(a_result_source, clk_i, rst_ni, $rose(out_valid_o), $past(!in_ready_o))

endmodule

bind multicast_route_table mrt_checker u_mrt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .hop_out_o      (hop_out_o),
  .prev_hop_out_o (prev_hop_out_o)
);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: multicast route table bench
// Drives upsert, set previous hop, remove and lookup commands through the
// valid/ready ports, predicts each result from a shadow copy of the table,
// and checks every result transfer in order under varied idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import mrt_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 1024;
  localparam int unsigned PhaseItems  = RandomItems / 4;
  localparam int unsigned PoolSize    = 24;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 40;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  hops;
    logic [31:0] prev_hop;
  } route_result_t;

  typedef struct {
    req_t          req;
    bit            typed;
    route_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [31:0] group_address;
  logic [31:0] prev_hop_in;
  logic [7:0]  hop_in;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [7:0]  hop_out;
  logic [31:0] prev_hop_out;

  // shadow copy of the route table
  logic        shadow_valid [TableEntries];
  logic [31:0] shadow_key   [TableEntries];
  logic [31:0] shadow_prev  [TableEntries];
  logic [7:0]  shadow_hops  [TableEntries];

  route_result_t pending_results[$];
  stim_row_t     directed_rows[$];
  logic [31:0]   key_pool[PoolSize];

  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;

  multicast_route_table dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .group_address_i(group_address),
    .prev_hop_in_i  (prev_hop_in),
    .hop_in_i       (hop_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .hop_out_o      (hop_out),
    .prev_hop_out_o (prev_hop_out)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one command to the shadow table and return its result
  function automatic route_result_t predict_route(req_t r);
    int            hit;
    int            free_idx;
    route_result_t res;
    hit      = -1;
    free_idx = -1;
    res      = '0;
    for (int i = 0; i < TableEntries; i++) begin
      if (shadow_valid[i] && shadow_key[i] == r.key && hit < 0) hit = i;
      if (!shadow_valid[i] && free_idx < 0) free_idx = i;
    end
    res.status = StatusOk;
    case (r.cmd)
      CmdUpsert: begin
        if (hit < 0 && free_idx < 0) begin
          res.status = StatusFull;
        end else begin
          if (hit < 0) begin
            hit = free_idx;
            shadow_valid[hit] = 1'b1;
            shadow_key[hit]   = r.key;
          end
          shadow_prev[hit] = r.prev_hop;
          shadow_hops[hit] = r.hops;
        end
      end
      CmdSetPrev: begin
        if (hit < 0) res.status = StatusNotFound;
        else shadow_prev[hit] = r.prev_hop;
      end
      CmdRemove: begin
        if (hit < 0) res.status = StatusNotFound;
        else shadow_valid[hit] = 1'b0;
      end
      default: begin
        if (hit < 0) begin
          res.status = StatusNotFound;
        end else begin
          res.hops     = shadow_hops[hit];
          res.prev_hop = shadow_prev[hit];
        end
      end
    endcase
    return res;
  endfunction

  function automatic void add_row(logic [1:0] c, logic [31:0] key, logic [31:0] prev,
                                  logic [7:0] hops, bit typed, route_result_t want);
    stim_row_t row;
    row.req   = '{cmd: c, key: key, prev_hop: prev, hops: hops};
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // offer one command, wait for its transfer, then queue the expected result
  task automatic issue_route_cmd(input req_t r, input bit typed, input route_result_t want);
    route_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    command       <= r.cmd;
    group_address <= r.key;
    prev_hop_in   <= r.prev_hop;
    hop_in        <= r.hops;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_route(r);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= ReportLimit) $display("%s", msg);
  endtask

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin : check_results
    route_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: status %0d hops %0d prev %h",
                                  status, hop_out, prev_hop_out));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || hop_out !== want.hops ||
            prev_hop_out !== want.prev_hop) begin
          report_mismatch($sformatf(
            "mismatch: expected status %0d hops %0d prev %h, got status %0d hops %0d prev %h",
            want.status, want.hops, want.prev_hop, status, hop_out, prev_hop_out));
        end
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned   n;
    int unsigned   roll;
    int unsigned   seg;
    logic [1:0]    cmd_code;
    req_t          r;
    route_result_t blank;
    route_result_t not_found;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    command       = CmdLookup;
    group_address = '0;
    prev_hop_in   = '0;
    hop_in        = '0;
    blank         = '0;
    not_found     = '{status: StatusNotFound, hops: 8'h00, prev_hop: 32'h0};
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;

    // pool: the directed fill keys, the all-ones key, and random keys
    foreach (key_pool[i]) begin
      if (i < TableEntries - 1) key_pool[i] = 32'hE000_0000 + i;
      else if (i == TableEntries - 1) key_pool[i] = 32'hFFFF_FFFF;
      else key_pool[i] = $urandom;
    end

    // directed rows: empty table, field extremes, updates, remove, fill to full
    add_row(CmdLookup,  32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1, not_found);
    add_row(CmdRemove,  32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1, not_found);
    add_row(CmdSetPrev, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, not_found);
    add_row(CmdUpsert,  32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1, blank);
    add_row(CmdUpsert,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, blank);
    add_row(CmdLookup,  32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 1'b1,
            '{status: StatusOk, hops: 8'hFF, prev_hop: 32'hFFFF_FFFF});
    add_row(CmdUpsert,  32'hFFFF_FFFF, 32'h5A5A_A5A5, 8'h80, 1'b0, blank);
    add_row(CmdSetPrev, 32'hFFFF_FFFF, 32'h0123_4567, 8'h01, 1'b0, blank);
    add_row(CmdLookup,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0, blank);
    add_row(CmdRemove,  32'h0000_0000, 32'h0000_0000, 8'h00, 1'b0, blank);
    add_row(CmdLookup,  32'h0000_0000, 32'h0000_0000, 8'h00, 1'b0, blank);
    for (int i = 0; i < TableEntries - 1; i++) begin
      add_row(CmdUpsert, key_pool[i], 32'h1000_0000 + i, 8'(i + 1), 1'b0, blank);
    end
    add_row(CmdUpsert, 32'hE000_00FF, 32'h0000_0001, 8'h01, 1'b1,
            '{status: StatusFull, hops: 8'h00, prev_hop: 32'h0});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      issue_route_cmd(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
    end

    // random part: fill, drain and balanced stretches over a small key pool
    for (n = 0; n < RandomItems; n++) begin
      if (n % PhaseItems == 0) begin
        case (n / PhaseItems)
          0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            hold_request   = HoldCycles;
          end
          1: begin
            send_idle_pct  = 45;
            recv_stall_pct = 0;
          end
          2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 45;
          end
          default: begin
            send_idle_pct  = 15;
            recv_stall_pct = 15;
            hold_request   = HoldCycles;
          end
        endcase
      end
      seg  = (n / 40) % 3;
      roll = $urandom_range(99);
      case (seg)
        0: cmd_code = (roll < 55) ? CmdUpsert : (roll < 65) ? CmdSetPrev :
                      (roll < 75) ? CmdRemove : CmdLookup;
        1: cmd_code = (roll < 15) ? CmdUpsert : (roll < 25) ? CmdSetPrev :
                      (roll < 70) ? CmdRemove : CmdLookup;
        default: cmd_code = (roll < 25) ? CmdUpsert : (roll < 50) ? CmdSetPrev :
                            (roll < 75) ? CmdRemove : CmdLookup;
      endcase
      r.cmd      = cmd_code;
      // mostly pool keys so that hits and a full table occur, some stray keys
      r.key      = ($urandom_range(99) < 8) ? 32'($urandom)
                                            : key_pool[$urandom_range(PoolSize - 1)];
      r.prev_hop = $urandom;
      r.hops     = 8'($urandom_range(255));
      issue_route_cmd(r, 1'b0, blank);
    end

    // wind down: stop offering, let every result arrive
    in_valid       <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
